FILE: sv/tlbr_pkg.sv
// shared types and constants for the fully associative translation buffer
// no dependencies; imported by tlb_lru_fifo_replace and its checker
`default_nettype none

package tlbr_pkg;

  localparam int EntriesDef   = 16;
  localparam int PageBitsDef  = 20;
  localparam int FrameBitsDef = 20;
  localparam int AgeBitsDef   = 8;

  // op field width and reported slot width are fixed by the stream format
  localparam int OP_W   = 2;
  localparam int SLOT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_FILL   = 2'd1,
    OP_FLUSH  = 2'd2
  } op_e;

endpackage

`default_nettype wire

FILE: sv/tlb_lru_fifo_replace.sv
// fully associative translation buffer with lru or fifo replacement
// depends on tlbr_pkg (op codes, field widths, parameter defaults)
//
//  channel   dir  handshake                      contents
//  s_axis    in   s_axis_tvalid / s_axis_tready  tuser: op; tdata: page, frame
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: hit, frame_out, slot, evicted
//  cfg       in   cfg_we_i                       cfg_wdata_i: use_lru
//
// one beat per cycle sustained while m_axis_tready is high; a taken beat reaches m_axis through
// the input register, then tag compare / victim tree / state update into the result register
// the victim search is a registered-free compare tree over ENTRIES ages in that one stage
// reset clears valid bits, ages, fifo pointer and pipeline, and selects lru mode
// a stalled result holds the result register; the input register still takes a new beat
// while it is empty, or while the result register is free or being drained
`default_nettype none

module tlb_lru_fifo_replace #(
  parameter int ENTRIES    = tlbr_pkg::EntriesDef,
  parameter int PAGE_BITS  = tlbr_pkg::PageBitsDef,
  parameter int FRAME_BITS = tlbr_pkg::FrameBitsDef,
  parameter int AGE_BITS   = tlbr_pkg::AgeBitsDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic                     cfg_wdata_i,
  input  wire logic                     s_axis_tvalid,
  output logic                          s_axis_tready,
  // page_number, frame_number, zero pad
  input  wire logic [((PAGE_BITS+FRAME_BITS+7)/8)*8-1:0] s_axis_tdata,
  // op
  input  wire logic [tlbr_pkg::OP_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  wire logic                     m_axis_tready,
  // hit, frame_out, slot, evicted, zero pad
  output logic [((FRAME_BITS+tlbr_pkg::SLOT_W+2+7)/8)*8-1:0] m_axis_tdata
);
  import tlbr_pkg::*;

  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int LEAVES      = 1 << IDX_W;
  localparam int OUT_W       = FRAME_BITS + SLOT_W + 2;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // mode register
  logic use_lru_q;

  // input stage
  logic                  in_valid_q;
  op_e                   in_op_q;
  logic [PAGE_BITS-1:0]  in_page_q;
  logic [FRAME_BITS-1:0] in_frame_q;

  // entry state
  logic [ENTRIES-1:0]    valid_q, valid_d;
  logic [PAGE_BITS-1:0]  tag_q   [ENTRIES];
  logic [FRAME_BITS-1:0] frame_q [ENTRIES];
  logic [AGE_BITS-1:0]   age_q   [ENTRIES];
  logic [AGE_BITS-1:0]   age_d   [ENTRIES];
  logic [AGE_BITS-1:0]   aged    [ENTRIES];
  logic [IDX_W-1:0]      ptr_q, ptr_d;

  // result stage
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                  advance;
  logic [ENTRIES-1:0]    match;
  logic                  hit_any;
  logic [IDX_W-1:0]      hit_idx;
  logic [IDX_W-1:0]      free_idx;
  logic                  full;
  logic [IDX_W-1:0]      victim;
  logic [IDX_W-1:0]      target;
  logic                  fill_we;

  logic                  r_hit;
  logic [FRAME_BITS-1:0] r_frame;
  logic [SLOT_W-1:0]     r_slot;
  logic                  r_evict;

  logic [AGE_BITS-1:0]   node_age [1:2*LEAVES-1];
  logic [IDX_W-1:0]      node_idx [1:2*LEAVES-1];

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------- mode register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_lru_q <= 1'b1;
    end else if (cfg_we_i) begin
      use_lru_q <= cfg_wdata_i;
    end
  end

  // ---------------- input register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op_q    <= op_e'(s_axis_tuser);
      in_page_q  <= s_axis_tdata[PAGE_BITS-1:0];
      in_frame_q <= s_axis_tdata[PAGE_BITS+FRAME_BITS-1:PAGE_BITS];
    end
  end

  // ---------------- compare and search ----------------
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_q[i] && (tag_q[i] == in_page_q);
      aged[i]  = (use_lru_q && (age_q[i] != AGE_MAX)) ? age_q[i] + AGE_BITS'(1) : age_q[i];
    end
  end

  assign hit_any = |match;
  assign full    = &valid_q;

  // lowest matching entry and lowest free entry
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_idx = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_idx = IDX_W'(i);
      end
    end
  end

  // oldest entry after aging, left wins ties so the lower index is kept
  for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
    if (g < ENTRIES) begin : g_real
      assign node_age[LEAVES+g] = aged[g];
    end else begin : g_pad
      assign node_age[LEAVES+g] = '0;
    end
    assign node_idx[LEAVES+g] = IDX_W'(g);
  end

  for (genvar n = 1; n < LEAVES; n++) begin : g_node
    logic take_r;
    assign take_r      = node_age[2*n+1] > node_age[2*n];
    assign node_age[n] = take_r ? node_age[2*n+1] : node_age[2*n];
    assign node_idx[n] = take_r ? node_idx[2*n+1] : node_idx[2*n];
  end

  assign victim = node_idx[1];

  always_comb begin
    if (!full) begin
      target = free_idx;
    end else if (use_lru_q) begin
      target = victim;
    end else begin
      target = ptr_q;
    end
  end

  // ---------------- state update and result ----------------
  always_comb begin
    valid_d = valid_q;
    age_d   = age_q;
    ptr_d   = ptr_q;
    fill_we = 1'b0;
    r_hit   = 1'b0;
    r_frame = '0;
    r_slot  = '0;
    r_evict = 1'b0;
    if (advance) begin
      case (in_op_q)
        OP_LOOKUP: begin
          if (hit_any) begin
            age_d[hit_idx] = '0;
            r_hit          = 1'b1;
            r_frame        = frame_q[hit_idx];
            r_slot         = SLOT_W'(hit_idx);
          end
        end
        OP_FILL: begin
          age_d           = aged;
          age_d[target]   = '0;
          valid_d[target] = 1'b1;
          fill_we         = 1'b1;
          r_slot          = SLOT_W'(target);
          if (full) begin
            r_evict = 1'b1;
            if (!use_lru_q) begin
              ptr_d = (ptr_q == IDX_W'(ENTRIES - 1)) ? '0 : ptr_q + IDX_W'(1);
            end
          end
        end
        OP_FLUSH: begin
          valid_d = '0;
          ptr_d   = '0;
          for (int i = 0; i < ENTRIES; i++) begin
            age_d[i] = '0;
          end
        end
        default: begin
        end
      endcase
    end
    out_data_d = OUT_TDATA_W'({r_evict, r_slot, r_frame, r_hit});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        age_q[i] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      ptr_q   <= ptr_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fill_we) begin
      tag_q[target]   <= in_page_q;
      frame_q[target] <= in_frame_q;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tlbr_checker.sv
// port-level checks for tlb_lru_fifo_replace, attached by the bind below
// depends on tlbr_pkg for the result field widths
`default_nettype none

module tlbr_checker #(
  parameter int FRAME_BITS = tlbr_pkg::FrameBitsDef
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     s_axis_tready,
  input wire logic                     m_axis_tvalid,
  input wire logic                     m_axis_tready,
  // hit, frame_out, slot, evicted, zero pad
  input wire logic [((FRAME_BITS+tlbr_pkg::SLOT_W+2+7)/8)*8-1:0] m_axis_tdata
);
  import tlbr_pkg::*;

  // input side only backs up when a result is waiting on the output
  a_ready_low_needs_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // no result beat is offered while reset is held
  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result data changed while stalled");

endmodule

bind tlb_lru_fifo_replace tlbr_checker #(
  .FRAME_BITS (FRAME_BITS)
) u_tlbr_checker (.*);

`default_nettype wire
